[src/cara_pkg.sv]
package cara_pkg;

	// field widths
	localparam int ID_W      = 10;
	localparam int MEM_W     = 33;
	localparam int WORKER_W  = 4;
	localparam int NUMW_W    = 5;
	localparam int CFG_IDX_W = 2;

	// stream word widths, tdata padded to whole bytes
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORKERS = 2'd1;

	// register reset values
	localparam logic [MEM_W-1:0]  CAPACITY_RESET = 33'h1_0000_0000;
	localparam logic [NUMW_W-1:0] NUMW_RESET     = 5'd16;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_LOOKUP = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	// result of the shared add and compare unit
	typedef struct packed {
		logic             fits;
		logic [MEM_W-1:0] sum;
	} fit_res_t;

endpackage

[src/cara_ram.sv]
module cara_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/cara_fit.sv]
module cara_fit
	import cara_pkg::*;
(
	input  logic [MEM_W-1:0] used,
	input  logic [MEM_W-1:0] req,
	input  logic [MEM_W-1:0] cap,
	output fit_res_t         res
);

	logic [MEM_W:0] sum_w;

	// one extra bit so that an overflowing sum never looks like a fit
	assign sum_w    = {1'b0, used} + {1'b0, req};
	assign res.fits = (sum_w <= {1'b0, cap});
	assign res.sum  = sum_w[MEM_W-1:0];

endmodule

[src/capacity_aware_round_robin_assigner.sv]
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------------------------
// s_       | in        | s_tvalid / s_tready | s_tdata: node_id, mem_request
// m_       | out       | m_tvalid / m_tready | m_tdata: worker; m_tuser: reused, full_res
// cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (capacity, num_workers)
//
// after reset a clearing pass over max(NODE_SLOTS, MAX_WORKERS) addresses zeroes the node map
// and the usage counters; s_tready stays low meanwhile, cfg writes are taken throughout
// a node already assigned is found in the first scan step, and its result word reaches the
// output register from the done state; a new node scans k workers (1 to the worker count),
// the usage counter memory read one worker per cycle through a single add and compare unit
// input reopens once the done state hands its result on, so one word is handled at a time
// a full output register only holds the finished result in the done state; the next word
// is accepted while a result still waits
module capacity_aware_round_robin_assigner
	import cara_pkg::*;
#(
	parameter int NODE_SLOTS  = 1024,
	parameter int MAX_WORKERS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] node_id, [42:10] mem_request, rest zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [3:0] worker, rest zero
	output logic [M_TUSER_W-1:0] m_tuser,   // [0] reused, [1] full_res
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MEM_W-1:0]     cfg_data
);

	// worker index width, worker count width, node map address width, clearing depth and counter width
	localparam int WIDX      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int EW        = $clog2(MAX_WORKERS + 1);
	localparam int NW        = $clog2(NODE_SLOTS);
	localparam int CLR_DEPTH = (NODE_SLOTS > MAX_WORKERS) ? NODE_SLOTS : MAX_WORKERS;
	localparam int CLR_W     = $clog2(CLR_DEPTH) + 1;

	state_t state_q;

	// configuration registers
	logic [MEM_W-1:0]  cap_q;
	logic [NUMW_W-1:0] numw_q;

	// item registers
	logic [NW-1:0]    slot_q;
	logic [MEM_W-1:0] mem_q;
	logic [WIDX-1:0]  sel_q;
	logic [EW-1:0]    cnt_q;
	logic             first_q;
	logic [WIDX-1:0]  next_start_q;
	logic [CLR_W-1:0] clr_q;

	// pending result, and the output register
	logic [WIDX-1:0]     res_worker_q;
	logic                res_reused_q;
	logic                res_full_q;
	logic                out_valid_q;
	logic [WORKER_W-1:0] out_worker_q;
	logic                out_reused_q;
	logic                out_full_q;

	logic [EW-1:0]    eff_n;
	logic [EW-1:0]    sel_inc;
	logic [WIDX-1:0]  sel_nxt;
	logic [WIDX-1:0]  sel_start;
	logic [ID_W-1:0]  slot_r;
	logic [ID_W-1:0]  in_id;
	logic [MEM_W-1:0] in_mem;
	logic             accept;
	logic             is_clear;
	logic             is_scan;
	logic             hit_old;
	logic             hit_new;
	logic             scan_last;
	logic             out_free;

	// memory ports
	logic             node_we;
	logic [NW-1:0]    node_waddr;
	logic [WIDX:0]    node_wdata;
	logic [WIDX:0]    node_rd;
	logic             used_we;
	logic [WIDX-1:0]  used_waddr;
	logic [MEM_W-1:0] used_wdata;
	logic             used_re;
	logic [WIDX-1:0]  used_raddr;
	logic [MEM_W-1:0] used_rd;
	fit_res_t         fit;

	assign in_id  = s_tdata[ID_W-1:0];
	assign in_mem = s_tdata[ID_W +: MEM_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign is_clear  = (state_q == ST_CLEAR);
	assign is_scan   = (state_q == ST_SCAN);
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_worker_q);
	assign m_tuser  = {out_full_q, out_reused_q};

	// effective worker count: zero counts as one, saturate at the built maximum
	always_comb begin
		if (numw_q == '0) begin
			eff_n = EW'(1);
		end else if (32'(numw_q) > MAX_WORKERS) begin
			eff_n = EW'(MAX_WORKERS);
		end else begin
			eff_n = EW'(numw_q);
		end
	end

	// round robin step and scan start
	assign sel_inc   = EW'(sel_q) + EW'(1);
	assign sel_nxt   = (sel_inc == eff_n) ? '0 : WIDX'(sel_inc);
	assign sel_start = (EW'(next_start_q) < eff_n) ? next_start_q : '0;

	// node id modulo slot count, by shifted compare and subtract
	always_comb begin
		slot_r = in_id;
		for (int k = ID_W - 1; k >= 0; k--) begin
			if (32'(slot_r) >= (32'(NODE_SLOTS) << k)) begin
				slot_r = slot_r - ID_W'(32'(NODE_SLOTS) << k);
			end
		end
	end

	// scan outcome for the worker whose counter is on the read port
	assign hit_old   = is_scan && first_q && node_rd[WIDX];
	assign hit_new   = is_scan && !(first_q && node_rd[WIDX]) && fit.fits;
	assign scan_last = (cnt_q == EW'(eff_n - EW'(1)));

	cara_fit u_fit (
		.used (used_rd),
		.req  (mem_q),
		.cap  (cap_q),
		.res  (fit)
	);

	// node map: assigned flag above the worker index
	assign node_we    = (is_clear && (clr_q < CLR_W'(NODE_SLOTS))) || hit_new;
	assign node_waddr = is_clear ? clr_q[NW-1:0] : slot_q;
	assign node_wdata = is_clear ? '0 : {1'b1, sel_q};

	cara_ram #(
		.WIDTH (WIDX + 1),
		.DEPTH (NODE_SLOTS)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (state_q == ST_LOOKUP),
		.raddr (slot_q),
		.rdata (node_rd)
	);

	// usage counters: read address runs one worker ahead of the compare
	assign used_we    = (is_clear && (clr_q < CLR_W'(MAX_WORKERS))) || hit_new;
	assign used_waddr = is_clear ? clr_q[WIDX-1:0] : sel_q;
	assign used_wdata = is_clear ? '0 : fit.sum;
	assign used_re    = (state_q == ST_LOOKUP) || is_scan;
	assign used_raddr = is_scan ? sel_nxt : sel_q;

	cara_ram #(
		.WIDTH (MEM_W),
		.DEPTH (MAX_WORKERS)
	) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.re    (used_re),
		.raddr (used_raddr),
		.rdata (used_rd)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAPACITY_RESET;
			numw_q <= NUMW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CAPACITY:    cap_q  <= cfg_data;
				CFG_NUM_WORKERS: numw_q <= cfg_data[NUMW_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			sel_q        <= '0;
			cnt_q        <= '0;
			first_q      <= 1'b0;
			next_start_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// load the output register from the done state, else drain it on ready
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						sel_q   <= sel_start;
						cnt_q   <= '0;
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					first_q <= 1'b1;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					first_q <= 1'b0;
					if (hit_old) begin
						state_q <= ST_DONE;
					end else if (hit_new) begin
						next_start_q <= sel_nxt;
						state_q      <= ST_DONE;
					end else if (scan_last) begin
						state_q <= ST_DONE;
					end else begin
						sel_q <= sel_nxt;
						cnt_q <= cnt_q + EW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= NW'(slot_r);
			mem_q  <= in_mem;
		end
		if (hit_old) begin
			res_worker_q <= node_rd[WIDX-1:0];
			res_reused_q <= 1'b1;
			res_full_q   <= 1'b0;
		end else if (hit_new) begin
			res_worker_q <= sel_q;
			res_reused_q <= 1'b0;
			res_full_q   <= 1'b0;
		end else if (is_scan && scan_last) begin
			res_worker_q <= '0;
			res_reused_q <= 1'b0;
			res_full_q   <= 1'b1;
		end
		if (state_q == ST_DONE && out_free) begin
			out_worker_q <= WORKER_W'(res_worker_q);
			out_reused_q <= res_reused_q;
			out_full_q   <= res_full_q;
		end
	end

endmodule

[src/cara_checker.sv]
module cara_checker
	import cara_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	// a result is never both reused and full
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("reused and full flagged together");

	// a full result names worker zero
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == '0))
		else $error("full result with nonzero worker");

	// one item at a time: input closes after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an accept");

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output word changed under stall");

endmodule

bind capacity_aware_round_robin_assigner cara_checker u_cara_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
